### hdl/ets_pkg.sv
package ets_pkg;

  localparam int unsigned MAX_STREAM_BYTES = 65536;
  localparam int unsigned OFF_W = 17;
  localparam int unsigned DIV_BITS = 30;
  localparam int unsigned DEN_W = 26;
  localparam int unsigned CNT_W = 5;

  localparam logic [13:0] REFRESH_SCALE = 14'd10000;
  localparam logic [13:0] CM_SQ_SCALE = 14'd10000;
  localparam logic [13:0] INCH_SQ = 14'd16129;     // 127 * 127, i.e. (2 * 2.54 * 25)^2
  localparam logic [31:0] DIAG_DSTEP = 32'd129032; // 8 * INCH_SQ
  localparam logic [6:0] BASE_DTD_LO = 7'd54;
  localparam logic [6:0] BASE_DTD_HI = 7'd126;
  localparam logic [7:0] CEA_TAG = 8'h02;
  localparam logic [4:0] DTD_LEN = 5'd18;
  localparam logic [4:0] DTD_TRIG = 5'd11;
  localparam logic [4:0] LETTER_MAX = 5'd26;

  // register indexes
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic take;
    logic div_load;
    logic div_step;
    logic div_end;
    logic diag_load;
    logic diag_lim;
    logic diag_step;
    logic out_load;
  } ets_cmd_t;

  typedef struct packed {
    logic div_req;
    logic div_done;
    logic diag_done;
    logic out_free;
  } ets_sts_t;

  // floor(x / 18) for x < 128 via reciprocal 57/1024
  function automatic logic [2:0] div18(input logic [6:0] x);
    logic [12:0] prod;
    prod = {6'd0, x} * 13'd57;
    return prod[12:10];
  endfunction

endpackage

### hdl/edid_timing_scan.sv
// Sequence: an ordinary word is taken in idle; a matching timing descriptor adds
// a divide (multiply, 30 single-bit restoring divide steps, update).
// A last word adds the incremental diagonal search after any divide,
// then the result is loaded into the output register when that register is free.
// Throughput: one word at a time, set by the shared divider and search.
// Reset: rst_n synchronous active low; clears control and stream state, targets to 0.
module edid_timing_scan (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_edid_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_refresh_hz,
  output logic [7:0]  out_diagonal_inches,
  output logic [4:0]  out_letter_first,
  output logic [4:0]  out_letter_second,
  output logic [4:0]  out_letter_third,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ets_pkg::ets_cmd_t cmd;
  ets_pkg::ets_sts_t sts;
  logic              busy;
  logic [11:0]       tgt_w_r, tgt_h_r;
  logic              cfg_wr;

  // register file: index taken from address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_w_r <= '0;
      tgt_h_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ets_pkg::REG_WIDTH:  tgt_w_r <= pwdata[11:0];
        ets_pkg::REG_HEIGHT: tgt_h_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ets_pkg::REG_WIDTH:  prdata = {20'd0, tgt_w_r};
      ets_pkg::REG_HEIGHT: prdata = {20'd0, tgt_h_r};
      default:             prdata = '0;
    endcase
  end

  ets_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  ets_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_edid_byte        (in_edid_byte),
    .target_width        (tgt_w_r),
    .target_height       (tgt_h_r),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_refresh_hz      (out_refresh_hz),
    .out_diagonal_inches (out_diagonal_inches),
    .out_letter_first    (out_letter_first),
    .out_letter_second   (out_letter_second),
    .out_letter_third    (out_letter_third)
  );

`ifndef SYNTH
  // never take a word while the divider or search is running
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("word taken while busy");

  // diagonal bounded by the largest size bytes
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_diagonal_inches <= 8'd142) else $error("diagonal out of range");

  // a result load always comes with the output register free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready)) else $error("result overwritten");

  // divide and search never overlap with taking a word
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.div_step, cmd.diag_step, cmd.out_load}))
    else $error("conflicting commands");
`endif

endmodule

### hdl/ets_ctrl.sv
module ets_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last_byte,
  output logic             in_ready,
  input  ets_pkg::ets_sts_t sts,
  output ets_pkg::ets_cmd_t cmd,
  output logic             busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DLOAD = 3'd1;
  localparam logic [2:0] S_DSTEP = 3'd2;
  localparam logic [2:0] S_DEND  = 3'd3;
  localparam logic [2:0] S_GLOAD = 3'd4;
  localparam logic [2:0] S_GLIM  = 3'd5;
  localparam logic [2:0] S_GSTEP = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r <= last_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    last_nxt = last_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          last_nxt = in_last_byte;
          if (sts.div_req) state_nxt = S_DLOAD;
          else if (in_last_byte) state_nxt = S_GLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DEND;
      end
      S_DEND: begin
        cmd.div_end = 1'b1;
        state_nxt = last_r ? S_GLOAD : S_IDLE;
      end
      S_GLOAD: begin
        cmd.diag_load = 1'b1;
        state_nxt = S_GLIM;
      end
      S_GLIM: begin
        cmd.diag_lim = 1'b1;
        state_nxt = S_GSTEP;
      end
      S_GSTEP: begin
        if (sts.diag_done) state_nxt = S_OUT;
        else cmd.diag_step = 1'b1;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### hdl/ets_dp.sv
module ets_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ets_pkg::ets_cmd_t cmd,
  output ets_pkg::ets_sts_t sts,
  input  logic [7:0]        in_edid_byte,
  input  logic [11:0]       target_width,
  input  logic [11:0]       target_height,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [15:0]       out_refresh_hz,
  output logic [7:0]        out_diagonal_inches,
  output logic [4:0]        out_letter_first,
  output logic [4:0]        out_letter_second,
  output logic [4:0]        out_letter_third
);

  logic [ets_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [7:0]  desc_r [8];
  logic [15:0] best_r, best_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        tag_ok_r, tag_ok_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  size_r [2];
  logic [7:0]  vend_r [2];
  logic        div_ext_r;

  // divider
  logic [ets_pkg::DIV_BITS-1:0] num_r, quo_r;
  logic [ets_pkg::DEN_W-1:0]    den_r;
  logic [ets_pkg::DEN_W:0]      rem_r, rem_sh;
  logic [ets_pkg::CNT_W-1:0]    cnt_r;
  logic [15:0]                  quo_sat;

  // diagonal search
  logic [16:0] sq_r;
  logic [31:0] lim_r, s_r, d_r;
  logic [7:0]  n_r;
  logic        size_zero;

  logic        out_valid_r;
  logic [15:0] o_ref_r;
  logic [7:0]  o_diag_r;
  logic [4:0]  o_l1_r, o_l2_r, o_l3_r;

  // byte decode
  logic        in_range, base_hit, ext_hit, dtd_hit;
  logic [6:0]  p, rel;
  logic [2:0]  j;
  logic [4:0]  r;
  logic [9:0]  dtd_end;
  logic [15:0] pclk;
  logic [11:0] hact, vact;
  logic [12:0] htot, vtot;
  logic        match;
  logic [15:0] word;

  assign p = off_r[6:0];
  assign in_range = (off_r < ets_pkg::OFF_W'(ets_pkg::MAX_STREAM_BYTES));

  always_comb begin
    base_hit = 1'b0;
    ext_hit = 1'b0;
    rel = '0;
    if (off_r < ets_pkg::OFF_W'(ets_pkg::BASE_DTD_HI) &&
        off_r >= ets_pkg::OFF_W'(ets_pkg::BASE_DTD_LO)) begin
      base_hit = 1'b1;
      rel = p - ets_pkg::BASE_DTD_LO;
    end else if (off_r >= ets_pkg::OFF_W'(128) && p != 7'd0 && p != 7'd2 &&
                 tag_ok_r && start_r >= 8'd4 && {1'b0, p} >= start_r) begin
      rel = p - start_r[6:0];
      ext_hit = 1'b1;
    end
  end

  assign j = ets_pkg::div18(rel);
  assign r = 5'(rel - 7'({4'd0, j} * 7'd18));
  assign dtd_end = {2'd0, start_r} + 10'({7'd0, j} + 10'd1) * 10'd18;
  assign dtd_hit = base_hit || (ext_hit && dtd_end <= 10'd128);

  assign pclk = {desc_r[1], desc_r[0]};
  assign hact = {desc_r[4][7:4], desc_r[2]};
  assign vact = {desc_r[7][7:4], desc_r[5]};
  assign htot = {1'b0, hact} + {1'b0, desc_r[4][3:0], desc_r[3]};
  assign vtot = {1'b0, vact} + {1'b0, desc_r[7][3:0], desc_r[6]};
  assign match = pclk != 16'd0 && hact == target_width && vact == target_height &&
                 htot != 13'd0 && vtot != 13'd0;

  assign sts.div_req = in_range && dtd_hit && r == ets_pkg::DTD_TRIG && match;
  assign sts.div_done = (cnt_r == ets_pkg::CNT_W'(ets_pkg::DIV_BITS - 1));
  assign sts.diag_done = (s_r > lim_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign rem_sh = {rem_r[ets_pkg::DEN_W-1:0], num_r[ets_pkg::DIV_BITS-1]};
  assign quo_sat = (quo_r > ets_pkg::DIV_BITS'(16'hFFFF)) ? 16'hFFFF : quo_r[15:0];

  // stream state
  always_comb begin
    off_nxt = off_r;
    best_nxt = best_r;
    pend_nxt = pend_r;
    tag_ok_nxt = tag_ok_r;
    start_nxt = start_r;
    if (cmd.take && in_range) begin
      off_nxt = off_r + 1'b1;
      if (off_r >= ets_pkg::OFF_W'(128)) begin
        if (p == 7'd0) begin
          pend_nxt = '0;
          tag_ok_nxt = (in_edid_byte == ets_pkg::CEA_TAG);
          start_nxt = '0;
        end else if (p == 7'd2) begin
          start_nxt = in_edid_byte;
        end
        if (p == 7'd127 && pend_r > best_r) best_nxt = pend_r;
      end
    end
    if (cmd.div_end) begin
      if (div_ext_r) begin
        if (quo_sat > pend_r) pend_nxt = quo_sat;
      end else if (quo_sat > best_r) begin
        best_nxt = quo_sat;
      end
    end
    if (cmd.out_load) begin
      off_nxt = '0;
      best_nxt = '0;
      pend_nxt = '0;
      tag_ok_nxt = 1'b0;
      start_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      best_r <= '0;
      pend_r <= '0;
      tag_ok_r <= 1'b0;
      start_r <= '0;
      size_r[0] <= '0;
      size_r[1] <= '0;
      vend_r[0] <= '0;
      vend_r[1] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      off_r <= off_nxt;
      best_r <= best_nxt;
      pend_r <= pend_nxt;
      tag_ok_r <= tag_ok_nxt;
      start_r <= start_nxt;
      if (cmd.out_load) begin
        size_r[0] <= '0;
        size_r[1] <= '0;
        vend_r[0] <= '0;
        vend_r[1] <= '0;
      end else if (cmd.take && in_range) begin
        if (off_r == ets_pkg::OFF_W'(8)) vend_r[0] <= in_edid_byte;
        if (off_r == ets_pkg::OFF_W'(9)) vend_r[1] <= in_edid_byte;
        if (off_r == ets_pkg::OFF_W'(21)) size_r[0] <= in_edid_byte;
        if (off_r == ets_pkg::OFF_W'(22)) size_r[1] <= in_edid_byte;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take && in_range && dtd_hit && r < 5'd8) desc_r[r[2:0]] <= in_edid_byte;
    if (cmd.take) div_ext_r <= ext_hit;
    if (cmd.div_load) begin
      num_r <= ets_pkg::DIV_BITS'({14'd0, pclk} * {16'd0, ets_pkg::REFRESH_SCALE});
      den_r <= {13'd0, htot} * {13'd0, vtot};
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[ets_pkg::DIV_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_sh - {1'b0, den_r};
        quo_r <= {quo_r[ets_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[ets_pkg::DIV_BITS-2:0], 1'b0};
      end
    end
    if (cmd.diag_load) begin
      sq_r <= 17'({8'd0, size_r[0]} * {8'd0, size_r[0]}) +
              17'({8'd0, size_r[1]} * {8'd0, size_r[1]});
    end
    if (cmd.diag_lim) begin
      lim_r <= 32'({15'd0, sq_r} * {18'd0, ets_pkg::CM_SQ_SCALE});
      s_r <= {18'd0, ets_pkg::INCH_SQ};
      d_r <= ets_pkg::DIAG_DSTEP;
      n_r <= '0;
    end else if (cmd.diag_step) begin
      s_r <= s_r + d_r;
      d_r <= d_r + ets_pkg::DIAG_DSTEP;
      n_r <= n_r + 1'b1;
    end
    if (cmd.out_load) begin
      o_ref_r <= best_r;
      o_diag_r <= size_zero ? 8'd0 : n_r;
      o_l1_r <= (off_r >= ets_pkg::OFF_W'(10) && word[14:10] != 5'd0 &&
                 word[14:10] <= ets_pkg::LETTER_MAX) ? word[14:10] : 5'd0;
      o_l2_r <= (off_r >= ets_pkg::OFF_W'(10) && word[9:5] != 5'd0 &&
                 word[9:5] <= ets_pkg::LETTER_MAX) ? word[9:5] : 5'd0;
      o_l3_r <= (off_r >= ets_pkg::OFF_W'(10) && word[4:0] != 5'd0 &&
                 word[4:0] <= ets_pkg::LETTER_MAX) ? word[4:0] : 5'd0;
    end
  end

  assign size_zero = (size_r[0] == 8'd0) || (size_r[1] == 8'd0);
  assign word = {vend_r[0], vend_r[1]};

  assign out_valid = out_valid_r;
  assign out_refresh_hz = o_ref_r;
  assign out_diagonal_inches = o_diag_r;
  assign out_letter_first = o_l1_r;
  assign out_letter_second = o_l2_r;
  assign out_letter_third = o_l3_r;

endmodule
